/* hdl/wlc_pkg.sv */
// Shared types and constants of the windowed layer compositor.
`default_nettype none

package wlc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgDisplayControl = 3'd0;
  localparam logic [2:0] CfgWin0Vertical   = 3'd1;
  localparam logic [2:0] CfgWin1Vertical   = 3'd2;
  localparam logic [2:0] CfgWindowMasks    = 3'd3;
  localparam logic [2:0] CfgBlendControl   = 3'd4;
  localparam logic [2:0] CfgBlendWeights   = 3'd5;
  localparam logic [2:0] CfgBackdropColor  = 3'd6;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 32;

  // Layer target codes, one bit per layer as in the target and mask fields.
  localparam logic [5:0] TgtBg0      = 6'b000001;
  localparam logic [5:0] TgtBg1      = 6'b000010;
  localparam logic [5:0] TgtBg2      = 6'b000100;
  localparam logic [5:0] TgtSprite   = 6'b010000;
  localparam logic [5:0] TgtBackdrop = 6'b100000;

  localparam logic [1:0]  ModeAlpha      = 2'd1;
  localparam logic [7:0]  BackdropPrio   = 8'h30;
  localparam logic [7:0]  FullWindowLine = 8'hE8;
  localparam logic [14:0] BlankColor     = 15'h7FFF;
  localparam logic [4:0]  ChanMax        = 5'h1F;
  localparam logic [4:0]  WeightMax      = 5'd16;

  localparam int SemiTransBit = 16;
  localparam int EffectsBit   = 5;

  typedef struct packed {
    logic [2:0]  display_control;
    logic [15:0] win0_vertical;
    logic [15:0] win1_vertical;
    logic [31:0] window_layer_masks;
    logic [15:0] blend_control;
    logic [15:0] blend_weights;
    logic [14:0] backdrop_color;
  } cfg_t;

  // First stage result: layer words and the window mask in force.
  typedef struct packed {
    logic        blank;
    logic [5:0]  mask;
    logic [31:0] bg0;
    logic [31:0] bg1;
    logic [31:0] bg2;
    logic [31:0] sprite;
  } win_t;

  // Second stage result: the two colors and whether to blend them.
  typedef struct packed {
    logic        blank;
    logic        blend;
    logic [14:0] color_a;
    logic [14:0] color_b;
  } sel_t;

endpackage

`default_nettype wire

/* hdl/wlc_window.sv */
// First pipeline stage: vertical window tests and window mask selection.
`default_nettype none

module wlc_window (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wlc_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [31:0]   bg0_i,
  input  wire logic [31:0]   bg1_i,
  input  wire logic [31:0]   bg2_i,
  input  wire logic [31:0]   sprite_i,
  input  wire logic          sprite_window_hit_i,
  input  wire logic          win0_column_hit_i,
  input  wire logic          win1_column_hit_i,
  input  wire logic [7:0]    scanline_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output wlc_pkg::win_t      data_o
);

  logic          valid_q;
  wlc_pkg::win_t data_q;
  wlc_pkg::win_t data_d;
  logic          win0_line;
  logic          win1_line;
  logic [7:0]    mask_sel;

  function automatic logic line_hit(input logic [15:0] span, input logic [7:0] line);
    logic [7:0] top;
    logic [7:0] bot;
    logic       hit;
    top = span[15:8];
    bot = span[7:0];
    hit = (top == bot) && (top >= wlc_pkg::FullWindowLine);
    if (bot >= top) begin
      hit = hit || ((line >= top) && (line < bot));
    end else begin
      hit = hit || (line >= top) || (line < bot);
    end
    return hit;
  endfunction

  assign win0_line = line_hit(cfg_i.win0_vertical, scanline_i);
  assign win1_line = line_hit(cfg_i.win1_vertical, scanline_i);

  // Window zero overrides window one, which overrides the object window.
  always_comb begin
    mask_sel = cfg_i.window_layer_masks[23:16];
    if (sprite_window_hit_i) begin
      mask_sel = cfg_i.window_layer_masks[31:24];
    end
    if (cfg_i.display_control[2] && win1_line && win1_column_hit_i) begin
      mask_sel = cfg_i.window_layer_masks[15:8];
    end
    if (cfg_i.display_control[1] && win0_line && win0_column_hit_i) begin
      mask_sel = cfg_i.window_layer_masks[7:0];
    end
  end

  always_comb begin
    data_d.blank  = cfg_i.display_control[0];
    data_d.mask   = mask_sel[5:0];
    data_d.bg0    = bg0_i;
    data_d.bg1    = bg1_i;
    data_d.bg2    = bg2_i;
    data_d.sprite = sprite_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hdl/wlc_select.sv */
// Second pipeline stage: top layer by priority and choice of the blend partner.
`default_nettype none

module wlc_select (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wlc_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire wlc_pkg::win_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output wlc_pkg::sel_t      data_o
);

  logic          valid_q;
  wlc_pkg::sel_t data_q;
  wlc_pkg::sel_t data_d;
  logic [31:0]   bd_word;
  logic [31:0]   top_word;
  logic [5:0]    top_sel;
  logic [31:0]   semi_word;
  logic [5:0]    semi_sel;
  logic [31:0]   alpha_word;
  logic [5:0]    alpha_sel;
  logic [5:0]    first_tgt;
  logic [5:0]    second_tgt;
  logic [1:0]    mode;

  assign bd_word    = {wlc_pkg::BackdropPrio, 9'd0, cfg_i.backdrop_color};
  assign first_tgt  = cfg_i.blend_control[5:0];
  assign second_tgt = cfg_i.blend_control[13:8];
  assign mode       = cfg_i.blend_control[7:6];

  // Background zero is compared on its whole word against the backdrop.
  always_comb begin
    top_word = bd_word;
    top_sel  = wlc_pkg::TgtBackdrop;
    if (data_i.mask[0] && (data_i.bg0 < bd_word)) begin
      top_word = data_i.bg0;
      top_sel  = wlc_pkg::TgtBg0;
    end
    if (data_i.mask[1] && (data_i.bg1[31:24] < top_word[31:24])) begin
      top_word = data_i.bg1;
      top_sel  = wlc_pkg::TgtBg1;
    end
    if (data_i.mask[2] && (data_i.bg2[31:24] < top_word[31:24])) begin
      top_word = data_i.bg2;
      top_sel  = wlc_pkg::TgtBg2;
    end
    if (data_i.mask[4] && (data_i.sprite[31:24] < top_word[31:24])) begin
      top_word = data_i.sprite;
      top_sel  = wlc_pkg::TgtSprite;
    end
  end

  // Partner for a semi-transparent top: best background, top not excluded.
  always_comb begin
    semi_word = bd_word;
    semi_sel  = wlc_pkg::TgtBackdrop;
    if (data_i.mask[0] && (data_i.bg0[31:24] < semi_word[31:24])) begin
      semi_word = data_i.bg0;
      semi_sel  = wlc_pkg::TgtBg0;
    end
    if (data_i.mask[1] && (data_i.bg1[31:24] < semi_word[31:24])) begin
      semi_word = data_i.bg1;
      semi_sel  = wlc_pkg::TgtBg1;
    end
    if (data_i.mask[2] && (data_i.bg2[31:24] < semi_word[31:24])) begin
      semi_word = data_i.bg2;
      semi_sel  = wlc_pkg::TgtBg2;
    end
  end

  // Partner for alpha mode: best visible layer other than the top one.
  always_comb begin
    alpha_word = bd_word;
    alpha_sel  = wlc_pkg::TgtBackdrop;
    if (data_i.mask[0] && (data_i.bg0[31:24] < alpha_word[31:24])
        && (top_sel != wlc_pkg::TgtBg0)) begin
      alpha_word = data_i.bg0;
      alpha_sel  = wlc_pkg::TgtBg0;
    end
    if (data_i.mask[1] && (data_i.bg1[31:24] < alpha_word[31:24])
        && (top_sel != wlc_pkg::TgtBg1)) begin
      alpha_word = data_i.bg1;
      alpha_sel  = wlc_pkg::TgtBg1;
    end
    if (data_i.mask[2] && (data_i.bg2[31:24] < alpha_word[31:24])
        && (top_sel != wlc_pkg::TgtBg2)) begin
      alpha_word = data_i.bg2;
      alpha_sel  = wlc_pkg::TgtBg2;
    end
    if (data_i.mask[4] && (data_i.sprite[31:24] < alpha_word[31:24])
        && (top_sel != wlc_pkg::TgtSprite)) begin
      alpha_word = data_i.sprite;
      alpha_sel  = wlc_pkg::TgtSprite;
    end
  end

  always_comb begin
    data_d.blank   = data_i.blank;
    data_d.color_a = top_word[14:0];
    data_d.color_b = alpha_word[14:0];
    data_d.blend   = 1'b0;
    if (top_word[wlc_pkg::SemiTransBit]) begin
      data_d.color_b = semi_word[14:0];
      data_d.blend   = |(semi_sel & second_tgt);
    end else if (data_i.mask[wlc_pkg::EffectsBit] && (mode == wlc_pkg::ModeAlpha)
                 && (|(top_sel & first_tgt))) begin
      data_d.blend   = |(alpha_sel & second_tgt);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* hdl/wlc_blend.sv */
// Third pipeline stage: per-channel weighted blend and the output register.
`default_nettype none

module wlc_blend (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wlc_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire wlc_pkg::sel_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output logic [14:0]        color_o
);

  logic        valid_q;
  logic [14:0] color_q;
  logic [14:0] color_d;
  logic [14:0] mixed;
  logic [4:0]  weight_a;
  logic [4:0]  weight_b;
  logic [10:0] chan_sum [3];
  logic [6:0]  chan_shr [3];

  assign weight_a = (cfg_i.blend_weights[4:0] > wlc_pkg::WeightMax) ?
                    wlc_pkg::WeightMax : cfg_i.blend_weights[4:0];
  assign weight_b = (cfg_i.blend_weights[12:8] > wlc_pkg::WeightMax) ?
                    wlc_pkg::WeightMax : cfg_i.blend_weights[12:8];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign chan_sum[c] = (11'(data_i.color_a[c*5 +: 5]) * 11'(weight_a))
                       + (11'(data_i.color_b[c*5 +: 5]) * 11'(weight_b));
    assign chan_shr[c] = chan_sum[c][10:4];
    assign mixed[c*5 +: 5] = (chan_shr[c] > 7'(wlc_pkg::ChanMax)) ?
                             wlc_pkg::ChanMax : chan_shr[c][4:0];
  end

  always_comb begin
    if (data_i.blank) begin
      color_d = wlc_pkg::BlankColor;
    end else if (data_i.blend) begin
      color_d = mixed;
    end else begin
      color_d = data_i.color_a;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      color_q <= color_d;
    end
  end

  assign valid_o = valid_q;
  assign color_o = color_q;

endmodule

`default_nettype wire

/* hdl/windowed_layer_compositor_core.sv */
// Windowed layer compositor: window masking, priority select and alpha blend.
//
// One pixel word enters on the s_axis channel and one 15-bit color leaves on
// the m_axis channel. The input word carries three background words, the
// sprite word, the three window hit bits and the scanline; the output word
// carries the mixed color, blue in 14:10, green in 9:5, red in 4:0.
// The user must write registers through cfg_we_i, cfg_index_i and cfg_wdata_i
// only while the pipeline is empty; the block does not enforce this. An index
// past the last register is ignored. The three register stages (window mask,
// priority select, blend with output register) are passed in that order. A
// new word is taken every cycle while m_axis_tready stays high, sustaining one
// pixel per clock. Each stage holds its word while the next one is full and
// stalled; when the receiver drops m_axis_tready the stages fill up one by one,
// and s_axis_tready falls only once all three hold a word. Nothing is lost or
// repeated. Reset empties the pipeline and zeroes the configuration registers.
`default_nettype none

module windowed_layer_compositor_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [wlc_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire logic [wlc_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // bg0_word, bg1_word, bg2_word, sprite_word, sprite_window_hit,
  // win0_column_hit, win1_column_hit, scanline, zero padding
  input  wire logic [143:0]                        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // mixed_color, zero padding
  output logic [15:0]                              m_axis_tdata
);

  wlc_pkg::cfg_t cfg_q;
  wlc_pkg::win_t win_data;
  wlc_pkg::sel_t sel_data;
  logic          win_valid;
  logic          win_ready;
  logic          sel_valid;
  logic          sel_ready;
  logic [14:0]   mixed_color;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wlc_pkg::CfgDisplayControl: cfg_q.display_control    <= cfg_wdata_i[2:0];
        wlc_pkg::CfgWin0Vertical:   cfg_q.win0_vertical      <= cfg_wdata_i[15:0];
        wlc_pkg::CfgWin1Vertical:   cfg_q.win1_vertical      <= cfg_wdata_i[15:0];
        wlc_pkg::CfgWindowMasks:    cfg_q.window_layer_masks <= cfg_wdata_i;
        wlc_pkg::CfgBlendControl:   cfg_q.blend_control      <= cfg_wdata_i[15:0];
        wlc_pkg::CfgBlendWeights:   cfg_q.blend_weights      <= cfg_wdata_i[15:0];
        wlc_pkg::CfgBackdropColor:  cfg_q.backdrop_color     <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  wlc_window u_window (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .valid_i             (s_axis_tvalid),
    .ready_o             (s_axis_tready),
    .bg0_i               (s_axis_tdata[31:0]),
    .bg1_i               (s_axis_tdata[63:32]),
    .bg2_i               (s_axis_tdata[95:64]),
    .sprite_i            (s_axis_tdata[127:96]),
    .sprite_window_hit_i (s_axis_tdata[128]),
    .win0_column_hit_i   (s_axis_tdata[129]),
    .win1_column_hit_i   (s_axis_tdata[130]),
    .scanline_i          (s_axis_tdata[138:131]),
    .valid_o             (win_valid),
    .ready_i             (win_ready),
    .data_o              (win_data)
  );

  wlc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (win_valid),
    .ready_o (win_ready),
    .data_i  (win_data),
    .valid_o (sel_valid),
    .ready_i (sel_ready),
    .data_o  (sel_data)
  );

  wlc_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .data_i  (sel_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .color_o (mixed_color)
  );

  assign m_axis_tdata = {1'b0, mixed_color};

endmodule

`default_nettype wire
